// ----- rtl/qclt_pkg.sv -----
// qclt_pkg: shared types and constants of the quoted command line tokenizer.
// Used by every module under rtl/. No dependencies.

package qclt_pkg;

    localparam int MAX_TOKENS  = 64;
    localparam int PENDING_MAX = 8;
    localparam int PEND_IDX_W  = $clog2(PENDING_MAX);
    localparam int PEND_CNT_W  = $clog2(PENDING_MAX + 1);
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int TNUM_W      = 6;
    localparam int FOUND_W     = 7;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_QUOTE = 8'd34;
    localparam logic [7:0] CH_LO_A  = 8'd97;
    localparam logic [7:0] CH_LO_Z  = 8'd122;
    localparam logic [7:0] CASE_OFS = 8'd32;

    localparam logic [1:0] EV_CHAR  = 2'd0;
    localparam logic [1:0] EV_CLOSE = 2'd1;
    localparam logic [1:0] EV_LINE  = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] line_byte;
    } in_t;

    typedef struct packed {
        logic [1:0]         event_res;
        logic [7:0]         token_char;
        logic [TNUM_W-1:0]  token_number;
        logic [FOUND_W-1:0] tokens_found;
        logic               last;
    } out_t;

    typedef enum logic [1:0] {
        OP_CHAR,
        OP_LINE_END,
        OP_EOL
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic       lf;
        logic [7:0] line_byte;
    } cmd_t;

endpackage

// ----- rtl/qclt_front.sv -----
// qclt_front: classifies incoming bytes into character, CR/LF and end-of-line commands.
// Depends on qclt_pkg; feeds qclt_fifo.

module qclt_front (
    input  logic           s_valid,
    output logic           s_ready,
    input  qclt_pkg::in_t  s_data,
    output logic           cmd_valid,
    input  logic           cmd_ready,
    output qclt_pkg::cmd_t cmd
);

    always_comb begin
        cmd           = '0;
        cmd.line_byte = s_data.line_byte;
        cmd.lf        = (s_data.line_byte == qclt_pkg::CH_LF);
        if (s_data.kind || (s_data.line_byte == 8'd0)) begin
            cmd.op = qclt_pkg::OP_EOL;
        end else if ((s_data.line_byte == qclt_pkg::CH_CR) ||
                     (s_data.line_byte == qclt_pkg::CH_LF)) begin
            cmd.op = qclt_pkg::OP_LINE_END;
        end else begin
            cmd.op = qclt_pkg::OP_CHAR;
        end
    end

    assign cmd_valid = s_valid;
    assign s_ready   = cmd_ready;

endmodule

// ----- rtl/qclt_fifo.sv -----
// qclt_fifo: short command queue between the classifier and the scanner.
// Depends on qclt_pkg (cmd_t, FIFO_DEPTH).

module qclt_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  qclt_pkg::cmd_t wr_data,
    output logic           rd_valid,
    input  logic           rd_pop,
    output qclt_pkg::cmd_t rd_data
);

    qclt_pkg::cmd_t                    mem_reg [qclt_pkg::FIFO_DEPTH];
    logic [qclt_pkg::FIFO_PTR_W-1:0]   wptr_reg, wptr_next;
    logic [qclt_pkg::FIFO_PTR_W-1:0]   rptr_reg, rptr_next;
    logic [qclt_pkg::FIFO_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                              do_wr;
    logic                              do_rd;

    assign wr_ready = (cnt_reg != qclt_pkg::FIFO_CNT_W'(qclt_pkg::FIFO_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    always_comb begin
        wptr_next = do_wr ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = do_rd ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
        if (do_wr) begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/qclt_back.sv -----
// qclt_back: scanner that runs queued commands, holds CR/LF bytes and emits events.
// Depends on qclt_pkg; reads commands from qclt_fifo.

module qclt_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cmd_valid,
    output logic           cmd_pop,
    input  qclt_pkg::cmd_t cmd,
    output logic           m_valid,
    input  logic           m_ready,
    output qclt_pkg::out_t m_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_BYTE,
        ST_OVF,
        ST_CLOSE,
        ST_LINE,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        MODE_GAP,
        MODE_PLAIN,
        MODE_QUOTED,
        MODE_DONE
    } mode_t;

    typedef logic [qclt_pkg::FOUND_W-1:0] tcnt_t;

    typedef struct packed {
        mode_t          mode;
        tcnt_t          cnt;
        logic           gen_v;
        qclt_pkg::out_t ev;
    } feed_t;

    function automatic qclt_pkg::out_t char_ev(tcnt_t cnt, logic [7:0] ch);
        qclt_pkg::out_t e;
        tcnt_t          m1;
        e  = '0;
        m1 = cnt - 1'b1;
        e.event_res    = qclt_pkg::EV_CHAR;
        e.token_char   = ch;
        e.token_number = m1[qclt_pkg::TNUM_W-1:0];
        if ((cnt == tcnt_t'(1)) && (ch >= qclt_pkg::CH_LO_A) && (ch <= qclt_pkg::CH_LO_Z)) begin
            e.token_char = ch - qclt_pkg::CASE_OFS;
        end
        return e;
    endfunction

    function automatic qclt_pkg::out_t close_ev(tcnt_t cnt);
        qclt_pkg::out_t e;
        tcnt_t          m1;
        e  = '0;
        m1 = cnt - 1'b1;
        e.event_res    = qclt_pkg::EV_CLOSE;
        e.token_number = m1[qclt_pkg::TNUM_W-1:0];
        return e;
    endfunction

    function automatic mode_t after_close(tcnt_t cnt);
        return (cnt >= tcnt_t'(qclt_pkg::MAX_TOKENS)) ? MODE_DONE : MODE_GAP;
    endfunction

    function automatic feed_t feed(mode_t mode, tcnt_t cnt, logic [7:0] ch);
        feed_t r;
        r.mode  = mode;
        r.cnt   = cnt;
        r.gen_v = 1'b0;
        r.ev    = '0;
        unique case (mode) inside
            MODE_GAP: begin
                if (ch != qclt_pkg::CH_SPACE) begin
                    r.cnt = cnt + 1'b1;
                    if (ch == qclt_pkg::CH_QUOTE) begin
                        r.mode = MODE_QUOTED;
                    end else begin
                        r.mode  = MODE_PLAIN;
                        r.gen_v = 1'b1;
                        r.ev    = char_ev(r.cnt, ch);
                    end
                end
            end
            MODE_PLAIN, MODE_QUOTED: begin
                r.gen_v = 1'b1;
                if (((mode == MODE_PLAIN) && (ch == qclt_pkg::CH_SPACE)) ||
                    ((mode == MODE_QUOTED) && (ch == qclt_pkg::CH_QUOTE))) begin
                    r.ev   = close_ev(cnt);
                    r.mode = after_close(cnt);
                end else begin
                    r.ev = char_ev(cnt, ch);
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    state_t                              state_reg, state_next;
    mode_t                               mode_reg, mode_next;
    tcnt_t                               tcnt_reg, tcnt_next;
    logic [qclt_pkg::PEND_CNT_W-1:0]     pcnt_reg, pcnt_next;
    logic [qclt_pkg::PENDING_MAX-1:0]    pend_reg, pend_next;
    qclt_pkg::cmd_t                      cmd_reg, cmd_next;
    logic                                held_v_reg, held_v_next;
    qclt_pkg::out_t                      held_reg, held_next;
    logic                                m_valid_reg, m_valid_next;
    qclt_pkg::out_t                      m_data_reg, m_data_next;

    logic                                out_free;
    logic                                step_ok;
    logic [7:0]                          feed_ch;
    feed_t                               f;
    logic                                gen_v;
    qclt_pkg::out_t                      gen_ev;

    assign out_free = !m_valid_reg || m_ready;
    assign step_ok  = !held_v_reg || out_free;
    assign feed_ch  = (state_reg == ST_BYTE) ? cmd_reg.line_byte :
                      (pend_reg[0] ? qclt_pkg::CH_LF : qclt_pkg::CH_CR);
    assign f        = feed(mode_reg, tcnt_reg, feed_ch);

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        tcnt_next    = tcnt_reg;
        pcnt_next    = pcnt_reg;
        pend_next    = pend_reg;
        cmd_next     = cmd_reg;
        held_v_next  = held_v_reg;
        held_next    = held_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        cmd_pop      = 1'b0;
        gen_v        = 1'b0;
        gen_ev       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    unique case (cmd.op)
                        qclt_pkg::OP_CHAR: begin
                            state_next = (pcnt_reg != '0) ? ST_DRAIN : ST_BYTE;
                        end
                        qclt_pkg::OP_LINE_END: begin
                            if (pcnt_reg == qclt_pkg::PEND_CNT_W'(qclt_pkg::PENDING_MAX)) begin
                                state_next = ST_OVF;
                            end else begin
                                pend_next[pcnt_reg[qclt_pkg::PEND_IDX_W-1:0]] = cmd.lf;
                                pcnt_next  = pcnt_reg + 1'b1;
                                state_next = ST_FIN;
                            end
                        end
                        qclt_pkg::OP_EOL: begin
                            state_next = ST_CLOSE;
                        end
                        default: begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_DRAIN: begin
                if (step_ok) begin
                    mode_next = f.mode;
                    tcnt_next = f.cnt;
                    gen_v     = f.gen_v;
                    gen_ev    = f.ev;
                    pend_next = pend_reg >> 1;
                    pcnt_next = pcnt_reg - 1'b1;
                    if (pcnt_reg == qclt_pkg::PEND_CNT_W'(1)) begin
                        state_next = ST_BYTE;
                    end
                end
            end
            ST_BYTE: begin
                if (step_ok) begin
                    mode_next  = f.mode;
                    tcnt_next  = f.cnt;
                    gen_v      = f.gen_v;
                    gen_ev     = f.ev;
                    state_next = ST_FIN;
                end
            end
            ST_OVF: begin
                if (step_ok) begin
                    mode_next  = f.mode;
                    tcnt_next  = f.cnt;
                    gen_v      = f.gen_v;
                    gen_ev     = f.ev;
                    pend_next  = {cmd_reg.lf, pend_reg[qclt_pkg::PENDING_MAX-1:1]};
                    state_next = ST_FIN;
                end
            end
            ST_CLOSE: begin
                if (step_ok) begin
                    if ((mode_reg == MODE_PLAIN) || (mode_reg == MODE_QUOTED)) begin
                        gen_v  = 1'b1;
                        gen_ev = close_ev(tcnt_reg);
                    end
                    state_next = ST_LINE;
                end
            end
            ST_LINE: begin
                if (step_ok) begin
                    gen_v               = 1'b1;
                    gen_ev              = '0;
                    gen_ev.event_res    = qclt_pkg::EV_LINE;
                    gen_ev.tokens_found = tcnt_reg;
                    mode_next           = MODE_GAP;
                    tcnt_next           = '0;
                    pcnt_next           = '0;
                    state_next          = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!held_v_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_data_next      = held_reg;
                    m_data_next.last = 1'b1;
                    held_v_next      = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a new event pushes the held one out; the last flag is only known at the end
        if (gen_v) begin
            if (held_v_reg) begin
                m_valid_next     = 1'b1;
                m_data_next      = held_reg;
                m_data_next.last = 1'b0;
            end
            held_next   = gen_ev;
            held_v_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_GAP;
            tcnt_reg    <= '0;
            pcnt_reg    <= '0;
            held_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            tcnt_reg    <= tcnt_next;
            pcnt_reg    <= pcnt_next;
            held_v_reg  <= held_v_next;
            m_valid_reg <= m_valid_next;
        end
        pend_reg   <= pend_next;
        cmd_reg    <= cmd_next;
        held_reg   <= held_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- rtl/quoted_command_line_tokenizer.sv -----
// quoted_command_line_tokenizer: top level; classifier, command queue and scanner.
// Depends on qclt_pkg, qclt_front, qclt_fifo, qclt_back.
//
//   channel | handshake          | payload
//   input   | s_valid / s_ready  | s_data  (qclt_pkg::in_t:  kind, line_byte)
//   result  | m_valid / m_ready  | m_data  (qclt_pkg::out_t: event, char, number, count, last)
//
// Scanner steps: a byte is fetch, a replay per held CR/LF, scan, finish; end of line is
// fetch, close, line, finish; a CR/LF is fetch, finish, with a replay when the buffer is full.
// The scanner runs one command at a time; a 4-entry queue lets input keep arriving meanwhile.
// Reset is synchronous, active low; it clears the queue and the scanner state.
// A stalled result channel stops the scanner once one event is held and one is on the port.

module quoted_command_line_tokenizer (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  qclt_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output qclt_pkg::out_t m_data
);

    logic           wr_valid;
    logic           wr_ready;
    qclt_pkg::cmd_t wr_cmd;
    logic           rd_valid;
    logic           rd_pop;
    qclt_pkg::cmd_t rd_cmd;

    qclt_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (wr_valid),
        .cmd_ready (wr_ready),
        .cmd       (wr_cmd)
    );

    qclt_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_data  (wr_cmd),
        .rd_valid (rd_valid),
        .rd_pop   (rd_pop),
        .rd_data  (rd_cmd)
    );

    qclt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (rd_valid),
        .cmd_pop   (rd_pop),
        .cmd       (rd_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    a_line_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.event_res == qclt_pkg::EV_LINE) |-> m_data.last)
        else $error("line finished event not marked last");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.event_res == qclt_pkg::EV_LINE) |->
        (m_data.tokens_found <= qclt_pkg::FOUND_W'(qclt_pkg::MAX_TOKENS)))
        else $error("token count beyond limit");

    a_char_only_on_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.event_res != qclt_pkg::EV_CHAR) |-> (m_data.token_char == 8'd0))
        else $error("character on non-character event");

    a_pop_needs_data: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pop |-> rd_valid)
        else $error("scanner popped an empty queue");

endmodule

// ----- bench/tb_quoted_command_line_tokenizer.sv -----
// tb_quoted_command_line_tokenizer: self-checking bench for the command line tokenizer.
// Depends on qclt_pkg and quoted_command_line_tokenizer; predicts events per byte and
// checks every result transaction in order under random idling on both channels.
`timescale 1ns / 1ps

module tb_quoted_command_line_tokenizer;
    import qclt_pkg::*;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_EOL    = 1'b1;
    localparam int   STALL_LIMIT = 5000;
    localparam int   DRAIN_CYCLES = 40;

    typedef enum logic [1:0] {
        SCAN_GAP,
        SCAN_PLAIN,
        SCAN_QUOTED,
        SCAN_DONE
    } scan_mode_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent = 0;
    int mismatches = 0;
    int stall_cycles = 0;

    scan_mode_t  scan_st = SCAN_GAP;
    int unsigned tok_cnt = 0;
    logic        held_lf [0:PENDING_MAX-1];
    int unsigned held_cnt = 0;
    out_t        expected_events [$];

    quoted_command_line_tokenizer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // ---------------- event prediction ----------------

    function automatic void push_event(logic [1:0] ev, logic [7:0] ch,
                                       int unsigned num, int unsigned found);
        out_t e;
        e.event_res    = ev;
        e.token_char   = ch;
        e.token_number = TNUM_W'(num);
        e.tokens_found = FOUND_W'(found);
        e.last         = 1'b0;
        expected_events.push_back(e);
    endfunction

    function automatic void close_expected_token();
        push_event(EV_CLOSE, 8'd0, tok_cnt - 1, 0);
        scan_st = (tok_cnt >= MAX_TOKENS) ? SCAN_DONE : SCAN_GAP;
    endfunction

    function automatic void token_char_expected(logic [7:0] ch);
        logic [7:0] c;
        c = ch;
        if (tok_cnt == 1 && c >= CH_LO_A && c <= CH_LO_Z) begin
            c = c - CASE_OFS;
        end
        push_event(EV_CHAR, c, tok_cnt - 1, 0);
    endfunction

    function automatic void scan_char(logic [7:0] ch);
        case (scan_st)
            SCAN_GAP: begin
                if (ch != CH_SPACE) begin
                    tok_cnt++;
                    if (ch == CH_QUOTE) begin
                        scan_st = SCAN_QUOTED;
                    end else begin
                        scan_st = SCAN_PLAIN;
                        token_char_expected(ch);
                    end
                end
            end
            SCAN_PLAIN: begin
                if (ch == CH_SPACE) close_expected_token();
                else token_char_expected(ch);
            end
            SCAN_QUOTED: begin
                if (ch == CH_QUOTE) close_expected_token();
                else token_char_expected(ch);
            end
            default: ;
        endcase
    endfunction

    function automatic void tokenize_item(in_t item);
        int   n_before;
        out_t tail;
        n_before = expected_events.size();
        if (item.kind == KIND_EOL || item.line_byte == 8'd0) begin
            if (scan_st == SCAN_PLAIN || scan_st == SCAN_QUOTED) close_expected_token();
            push_event(EV_LINE, 8'd0, 0, tok_cnt);
            scan_st  = SCAN_GAP;
            tok_cnt  = 0;
            held_cnt = 0;
        end else if (item.line_byte == CH_CR || item.line_byte == CH_LF) begin
            if (held_cnt >= PENDING_MAX) begin
                scan_char(held_lf[0] ? CH_LF : CH_CR);
                for (int i = 1; i < PENDING_MAX; i++) held_lf[i-1] = held_lf[i];
                held_cnt = PENDING_MAX - 1;
            end
            held_lf[held_cnt] = (item.line_byte == CH_LF);
            held_cnt++;
        end else begin
            for (int i = 0; i < held_cnt; i++) scan_char(held_lf[i] ? CH_LF : CH_CR);
            held_cnt = 0;
            scan_char(item.line_byte);
        end
        if (expected_events.size() > n_before) begin
            tail = expected_events.pop_back();
            tail.last = 1'b1;
            expected_events.push_back(tail);
        end
    endfunction

    // ---------------- driving ----------------

    task automatic send_item(input logic kind, input logic [7:0] b);
        in_t item;
        item.kind = kind;
        item.line_byte = b;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        tokenize_item(item);
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(KIND_BYTE, b);
    endtask

    task automatic end_line();
        if ($urandom_range(1)) send_item(KIND_EOL, 8'($urandom_range(255)));
        else send_item(KIND_BYTE, 8'd0);
    endtask

    task automatic send_cr_or_lf();
        send_byte($urandom_range(1) ? CH_CR : CH_LF);
    endtask

    function automatic logic [7:0] pick_word_byte();
        case ($urandom_range(3))
            0, 1: return 8'($urandom_range(97, 122));
            2: return 8'($urandom_range(65, 90));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic send_word(input bit quoted);
        int len;
        len = $urandom_range(quoted ? 0 : 1, 6);
        if (quoted) send_byte(CH_QUOTE);
        repeat (len) begin
            if ($urandom_range(99) < 8) send_cr_or_lf();
            else if (quoted && $urandom_range(99) < 15) send_byte(CH_SPACE);
            else send_byte(pick_word_byte());
        end
        if (quoted && $urandom_range(99) < 90) send_byte(CH_QUOTE);
    endtask

    // ---------------- result checking ----------------

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_event(input out_t got);
        out_t exp;
        exp = expected_events.pop_front();
        if (got.event_res !== exp.event_res)
            report_mismatch($sformatf("event_res got %0d expected %0d",
                                      got.event_res, exp.event_res));
        if (got.token_char !== exp.token_char)
            report_mismatch($sformatf("token_char got %h expected %h",
                                      got.token_char, exp.token_char));
        if (got.token_number !== exp.token_number)
            report_mismatch($sformatf("token_number got %0d expected %0d",
                                      got.token_number, exp.token_number));
        if (got.tokens_found !== exp.tokens_found)
            report_mismatch($sformatf("tokens_found got %0d expected %0d",
                                      got.tokens_found, exp.tokens_found));
        if (got.last !== exp.last)
            report_mismatch($sformatf("last got %b expected %b", got.last, exp.last));
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (expected_events.size() == 0)
                report_mismatch($sformatf("unexpected result transaction %h", m_data));
            else
                check_event(m_data);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("FAILURE");
        $finish;
    end

    // ---------------- tests ----------------

    task automatic test_directed_tokens();
        send_item(KIND_EOL, 8'hFF);     // empty line
        send_byte("a");                 // first token is upper-cased
        send_byte(CH_QUOTE);            // quote inside plain token
        send_byte(CH_SPACE);
        send_byte(CH_QUOTE);
        send_byte(CH_SPACE);
        send_byte(8'hFF);
        send_byte(CH_QUOTE);
        send_byte("a");                 // text right after closing quote
        send_byte(CH_SPACE);
        send_byte(CH_QUOTE);            // empty quotes
        send_byte(CH_QUOTE);
        send_byte(8'h01);
        send_byte(CH_SPACE);
        send_byte(CH_QUOTE);            // quote left open at end of line
        send_byte("q");
        send_item(KIND_EOL, 8'h00);
    endtask

    task automatic test_directed_line_ends();
        for (int i = 0; i <= PENDING_MAX; i++) send_byte(i[0] ? CH_CR : CH_LF);
        send_byte("z");                 // replays full buffer into the first token
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(8'd0);                // held bytes dropped
    endtask

    task automatic test_random_lines(input int n_items);
        int stop_at;
        int ntok;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 20) begin
                repeat ($urandom_range(1, 12))
                    send_item($urandom_range(9) == 0, 8'($urandom_range(255)));
            end else begin
                ntok = $urandom_range(0, 6);
                for (int t = 0; t < ntok; t++) begin
                    repeat ($urandom_range(t == 0 ? 0 : 1, 2)) send_byte(CH_SPACE);
                    send_word($urandom_range(99) < 30);
                end
                if ($urandom_range(1)) repeat ($urandom_range(1, 3)) send_cr_or_lf();
            end
            end_line();
        end
    endtask

    task automatic test_line_end_runs(input int n_lines);
        repeat (n_lines) begin
            repeat ($urandom_range(1, 3)) begin
                send_byte(pick_word_byte());
                repeat ($urandom_range(0, PENDING_MAX + 4)) send_cr_or_lf();
            end
            end_line();
        end
    endtask

    task automatic test_token_limit();
        int ntok;
        ntok = $urandom_range(MAX_TOKENS - 1, MAX_TOKENS + 6);
        for (int t = 0; t < ntok; t++) begin
            if ($urandom_range(3) == 0) begin
                send_byte(CH_QUOTE);
                if ($urandom_range(1)) send_byte(pick_word_byte());
                send_byte(CH_QUOTE);
            end else begin
                send_byte(pick_word_byte());
                if (t != ntok - 1 || $urandom_range(1)) send_byte(CH_SPACE);
            end
        end
        repeat ($urandom_range(1, 4)) send_byte(pick_word_byte());
        end_line();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 35;
                    recv_idle_pct = 81;
                end
                1: begin
                    send_idle_pct = 81;
                    recv_idle_pct = 35;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 0) begin
                test_directed_tokens();
                test_directed_line_ends();
            end
            test_random_lines(30);
            test_line_end_runs(3);
            if (phase == 2) test_token_limit();
        end
        s_valid <= 1'b0;
        wait (expected_events.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule
